@@ rtl/pet_pkg.sv @@
// ----------------------------------------------------------------------------
// pet_pkg
// Shared types and constants of the pheromone edge table selector.
// ----------------------------------------------------------------------------
package pet_pkg;

    localparam int DEF_MAX_EDGES  = 512;
    localparam int DEF_MAX_DEGREE = 8;

    localparam int VERTEX_W = 7;
    localparam int INDEX_W  = 9;
    localparam int LEVEL_W  = 24;
    localparam int THR_W    = 16;
    localparam int ECNT_W   = 10;
    localparam int EVAP_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(4096);
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_DEPOSIT = 2'd1,
        OP_EVAP    = 2'd2,
        OP_SELECT  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_HOP  = 2'd1,
        ST_NONE = 2'd2
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_EVAP_AMT   = CFG_IDX_W'(1);

    // one decoded item on its way from front to back
    typedef struct packed {
        op_t                 op;
        logic                in_range;
        logic [INDEX_W-1:0]  idx;
        logic [VERTEX_W-1:0] end_a;
        logic [VERTEX_W-1:0] end_b;
        logic [LEVEL_W-1:0]  amount;
        logic [VERTEX_W-1:0] cur;
        logic [THR_W-1:0]    thr;
        logic                uni;
    } cmd_t;

    typedef struct packed {
        status_t             status;
        logic [VERTEX_W-1:0] next_vertex;
        logic [INDEX_W-1:0]  chosen_edge;
        logic                overflow;
    } res_t;

endpackage

@@ rtl/pet_front.sv @@
// ----------------------------------------------------------------------------
// pet_front
// Item intake: decodes items, holds config registers, two-entry item queue.
// ----------------------------------------------------------------------------
module pet_front
    import pet_pkg::*;
#(
    parameter int MAX_EDGES = DEF_MAX_EDGES,
    localparam int CW = $clog2(MAX_EDGES + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           mode,
    input  logic [INDEX_W-1:0]   edge_index,
    input  logic [VERTEX_W-1:0]  endpoint_a,
    input  logic [VERTEX_W-1:0]  endpoint_b,
    input  logic [LEVEL_W-1:0]   amount,
    input  logic [VERTEX_W-1:0]  current_vertex,
    input  logic [THR_W-1:0]     threshold,
    input  logic                 uniform_pick,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [EVAP_W-1:0]    cfg_data,
    output logic                 cmd_valid,
    output cmd_t                 cmd,
    input  logic                 cmd_pop,
    output logic [CW-1:0]        edges_used,
    output logic [EVAP_W-1:0]    evap_amt
);

    localparam int NW = (CW > ECNT_W) ? CW : ECNT_W;
    localparam int XW = (NW > INDEX_W) ? NW : INDEX_W;

    cmd_t              q_reg [2];
    logic              wp_reg, rp_reg;
    logic [1:0]        cnt_reg;
    logic [ECNT_W-1:0] ecnt_reg;
    logic [EVAP_W-1:0] evap_reg;
    cmd_t              in_cmd;
    logic              do_push;
    logic [NW-1:0]     ecnt_ext;

    assign cfg_ready = 1'b1;
    assign full      = (cnt_reg == 2'd2);
    assign do_push   = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];
    assign evap_amt  = evap_reg;

    // edge count above the table size counts as the table size
    assign ecnt_ext   = NW'(ecnt_reg);
    assign edges_used = (ecnt_ext > NW'(MAX_EDGES)) ? CW'(MAX_EDGES) : CW'(ecnt_ext);

    always_comb
    begin
        in_cmd.op       = op_t'(mode);
        in_cmd.in_range = (XW'(edge_index) < XW'(MAX_EDGES));
        in_cmd.idx      = edge_index;
        in_cmd.end_a    = endpoint_a;
        in_cmd.end_b    = endpoint_b;
        in_cmd.amount   = amount;
        in_cmd.cur      = current_vertex;
        in_cmd.thr      = threshold;
        in_cmd.uni      = uniform_pick;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wp_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            cnt_reg  <= 2'd0;
            ecnt_reg <= '0;
            evap_reg <= EVAP_W'(2048);
        end
        else
        begin
            if (do_push)
                wp_reg <= !wp_reg;
            if (cmd_pop)
                rp_reg <= !rp_reg;
            if (do_push && !cmd_pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (!do_push && cmd_pop)
                cnt_reg <= cnt_reg - 2'd1;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_EDGE_COUNT: ecnt_reg <= cfg_data[ECNT_W-1:0];
                    CFG_EVAP_AMT:   evap_reg <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cnt_reg != 2'd0)
        else $error("item queue popped while empty");
    a_count_push: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !cmd_pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("item queue count lost a push");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("item queue count out of range");

endmodule

@@ rtl/pet_back.sv @@
// ----------------------------------------------------------------------------
// pet_back
// Execution engine: edge table memory, scans, gather, sort and roulette pick.
// ----------------------------------------------------------------------------
module pet_back
    import pet_pkg::*;
#(
    parameter int MAX_EDGES  = DEF_MAX_EDGES,
    parameter int MAX_DEGREE = DEF_MAX_DEGREE,
    localparam int CW = $clog2(MAX_EDGES + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  cmd_t              cmd,
    output logic              cmd_pop,
    input  logic [CW-1:0]     edges_used,
    input  logic [EVAP_W-1:0] evap_amt,
    output logic              res_valid,
    output res_t              res,
    input  logic              res_pop
);

    localparam int AW   = $clog2(MAX_EDGES);
    localparam int MD   = MAX_DEGREE;
    localparam int SLW  = $clog2(MD);
    localparam int CNTW = $clog2(MD + 1);
    localparam int SW   = LEVEL_W + CNTW;
    localparam int PW   = SW + THR_W;
    localparam int UW   = THR_W + CNTW;

    typedef struct packed {
        logic [VERTEX_W-1:0] a;
        logic [VERTEX_W-1:0] b;
        logic [LEVEL_W-1:0]  lvl;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_DEP_RD, S_DEP_WR, S_EVAP, S_GATHER,
        S_SUM, S_SORT, S_MUL, S_SCAN, S_UNI, S_FIN
    } state_t;

    entry_t mem [MAX_EDGES];
    entry_t rdata_reg;
    logic   mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    entry_t mem_wdata;

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;
    logic   res_valid_reg, res_valid_next;
    res_t   res_reg, res_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] wa_reg, wa_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            over_reg, over_next;
    logic [VERTEX_W-1:0] nb_reg [MD];
    logic [VERTEX_W-1:0] nb_next [MD];
    logic [AW-1:0]       ed_reg [MD];
    logic [AW-1:0]       ed_next [MD];
    logic [LEVEL_W-1:0]  lv_reg [MD];
    logic [LEVEL_W-1:0]  lv_next [MD];
    logic [SLW-1:0]  i_reg, i_next;
    logic [SLW-1:0]  pick_reg, pick_next;
    logic [CNTW-1:0] phase_reg, phase_next;
    logic [SW-1:0]   sum_reg, sum_next;
    logic [SW-1:0]   cum_reg, cum_next;
    logic [PW-1:0]   ts_reg, ts_next;

    logic [CNTW-1:0] c1;
    logic [UW-1:0]   uprod;
    logic [CNTW-1:0] upick;
    logic [SW-1:0]   cum_sum;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign cmd_pop   = (state_reg == S_IDLE) && cmd_valid && !res_valid_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        ptr_next       = ptr_reg;
        pend_next      = pend_reg;
        wa_next        = wa_reg;
        cnt_next       = cnt_reg;
        over_next      = over_reg;
        nb_next        = nb_reg;
        ed_next        = ed_reg;
        lv_next        = lv_reg;
        i_next         = i_reg;
        pick_next      = pick_reg;
        phase_next     = phase_reg;
        sum_next       = sum_reg;
        cum_next       = cum_reg;
        ts_next        = ts_reg;
        mem_we         = 1'b0;
        mem_waddr      = AW'(cmd_reg.idx);
        mem_wdata      = rdata_reg;
        mem_raddr      = AW'(ptr_reg);
        c1             = '0;
        cum_sum        = cum_reg + SW'(lv_reg[i_reg]);
        uprod          = UW'(cmd_reg.thr) * UW'(cnt_reg);
        upick          = uprod[UW-1:THR_W];

        if (res_pop && res_valid_reg)
            res_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_pop)
                begin
                    cmd_next  = cmd;
                    ptr_next  = '0;
                    pend_next = 1'b0;
                    cnt_next  = '0;
                    over_next = 1'b0;
                    case (cmd.op)
                        OP_LOAD:    state_next = cmd.in_range ? S_LOAD : S_FIN;
                        OP_DEPOSIT: state_next = cmd.in_range ? S_DEP_RD : S_FIN;
                        OP_EVAP:    state_next = S_EVAP;
                        OP_SELECT:  state_next = S_GATHER;
                        default:    state_next = S_FIN;
                    endcase
                end
            end
            S_LOAD:
            begin
                mem_we     = 1'b1;
                mem_wdata  = '{a: cmd_reg.end_a, b: cmd_reg.end_b, lvl: cmd_reg.amount};
                state_next = S_FIN;
            end
            S_DEP_RD:
            begin
                mem_raddr  = AW'(cmd_reg.idx);
                state_next = S_DEP_WR;
            end
            S_DEP_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = rdata_reg;
                if ({1'b0, rdata_reg.lvl} + {1'b0, cmd_reg.amount} > {1'b0, LEVEL_MAX})
                    mem_wdata.lvl = LEVEL_MAX;
                else
                    mem_wdata.lvl = rdata_reg.lvl + cmd_reg.amount;
                state_next = S_FIN;
            end
            S_EVAP, S_GATHER:
            begin
                // read one entry a cycle, act on the entry read the cycle before
                if (ptr_reg < edges_used)
                begin
                    ptr_next  = ptr_reg + CW'(1);
                    pend_next = 1'b1;
                    wa_next   = AW'(ptr_reg);
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg && state_reg == S_EVAP)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wa_reg;
                    mem_wdata = rdata_reg;
                    if ({8'd0, rdata_reg.lvl} < {8'd0, LEVEL_W'(evap_amt)} + {8'd0, LEVEL_ONE})
                        mem_wdata.lvl = LEVEL_ONE;
                    else
                        mem_wdata.lvl = rdata_reg.lvl - LEVEL_W'(evap_amt);
                end
                if (pend_reg && state_reg == S_GATHER)
                begin
                    c1 = cnt_reg;
                    if (rdata_reg.b == cmd_reg.cur)
                    begin
                        if (c1 < CNTW'(MD))
                        begin
                            nb_next[SLW'(c1)] = rdata_reg.a;
                            ed_next[SLW'(c1)] = wa_reg;
                            lv_next[SLW'(c1)] = rdata_reg.lvl;
                            c1 = c1 + CNTW'(1);
                        end
                        else
                            over_next = 1'b1;
                    end
                    if (rdata_reg.a == cmd_reg.cur)
                    begin
                        if (c1 < CNTW'(MD))
                        begin
                            nb_next[SLW'(c1)] = rdata_reg.b;
                            ed_next[SLW'(c1)] = wa_reg;
                            lv_next[SLW'(c1)] = rdata_reg.lvl;
                            c1 = c1 + CNTW'(1);
                        end
                        else
                            over_next = 1'b1;
                    end
                    cnt_next = c1;
                end
                if (!(ptr_reg < edges_used) && !pend_reg)
                begin
                    if (state_reg == S_EVAP || cnt_reg == '0)
                        state_next = S_FIN;
                    else
                    begin
                        state_next = S_SUM;
                        i_next     = '0;
                        sum_next   = '0;
                    end
                end
            end
            S_SUM:
            begin
                sum_next = sum_reg + SW'(lv_reg[i_reg]);
                if (CNTW'(i_reg) == cnt_reg - CNTW'(1))
                begin
                    phase_next = '0;
                    if (cmd_reg.uni || sum_next == '0)
                        state_next = S_UNI;
                    else
                        state_next = S_SORT;
                end
                else
                    i_next = i_reg + SLW'(1);
            end
            S_SORT:
            begin
                // odd-even transposition, swap only on strictly greater: stable
                for (int k = 0; k < MD - 1; k++)
                begin
                    if ((1'(k) == phase_reg[0]) && (CNTW'(k + 1) < cnt_reg)
                        && (lv_reg[k] < lv_reg[k+1]))
                    begin
                        nb_next[k]   = nb_reg[k+1];
                        nb_next[k+1] = nb_reg[k];
                        ed_next[k]   = ed_reg[k+1];
                        ed_next[k+1] = ed_reg[k];
                        lv_next[k]   = lv_reg[k+1];
                        lv_next[k+1] = lv_reg[k];
                    end
                end
                phase_next = phase_reg + CNTW'(1);
                if (phase_reg == CNTW'(MD - 1))
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                ts_next    = PW'(cmd_reg.thr) * PW'(sum_reg);
                cum_next   = '0;
                i_next     = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cum_next = cum_sum;
                if (ts_reg <= {cum_sum, {THR_W{1'b0}}})
                begin
                    pick_next  = i_reg;
                    state_next = S_FIN;
                end
                else if (CNTW'(i_reg) == cnt_reg - CNTW'(1))
                begin
                    pick_next  = i_reg;
                    state_next = S_FIN;
                end
                else
                    i_next = i_reg + SLW'(1);
            end
            S_UNI:
            begin
                if (upick >= cnt_reg)
                    pick_next = SLW'(cnt_reg - CNTW'(1));
                else
                    pick_next = SLW'(upick);
                state_next = S_FIN;
            end
            S_FIN:
            begin
                res_valid_next = 1'b1;
                res_next       = '{status: ST_DONE, next_vertex: '0, chosen_edge: '0,
                                   overflow: 1'b0};
                if (cmd_reg.op == OP_SELECT)
                begin
                    if (cnt_reg == '0)
                        res_next.status = ST_NONE;
                    else
                    begin
                        res_next.status      = ST_HOP;
                        res_next.next_vertex = nb_reg[pick_reg];
                        res_next.chosen_edge = INDEX_W'(ed_reg[pick_reg]);
                        res_next.overflow    = over_reg;
                    end
                end
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        res_reg   <= res_next;
        ptr_reg   <= ptr_next;
        wa_reg    <= wa_next;
        cnt_reg   <= cnt_next;
        over_reg  <= over_next;
        nb_reg    <= nb_next;
        ed_reg    <= ed_next;
        lv_reg    <= lv_next;
        i_reg     <= i_next;
        pick_reg  <= pick_next;
        phase_reg <= phase_next;
        sum_reg   <= sum_next;
        cum_reg   <= cum_next;
        ts_reg    <= ts_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM || state_reg == S_SCAN || state_reg == S_FIN)
        |-> cnt_reg <= CNTW'(MD))
        else $error("gathered count above degree bound");
    a_pick_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && cmd_reg.op == OP_SELECT && cnt_reg != '0)
        |-> CNTW'(pick_reg) < cnt_reg)
        else $error("picked slot beyond gathered neighbors");
    a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !res_valid_reg && state_reg == S_IDLE)
        else $error("item started while result slot busy");
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |=> res_valid_reg && state_reg == S_IDLE)
        else $error("result not posted after finish");

endmodule

@@ rtl/pheromone_edge_table_selector.sv @@
// ----------------------------------------------------------------------------
// pheromone_edge_table_selector
// Edge table with pheromone updates and roulette-wheel next-hop selection.
// ----------------------------------------------------------------------------
// Items enter through a two-entry queue (push/full) and leave through a
// one-entry result slot (empty/pop), so intake keeps going while a result
// waits. The back end works on one item at a time against an edge memory
// of MAX_EDGES entries with one write port and one registered read port.
// Load writes one entry; deposit reads the entry and writes back the
// saturated sum; evaporate and select scan the first N entries, where N
// is the edge count in use (clamped to MAX_EDGES), and D below is the
// number of gathered neighbors (at most MAX_DEGREE). Select gathers
// incident edges in table order, sums their levels, sorts them stably by
// pheromone (odd-even passes), then walks the cumulative sum against
// threshold*sum. Uniform pick or a zero sum picks floor(threshold*D/65536)
// in gathered order. The table has no reset; edges below the edge count
// must be loaded before they are read. Config writes are always ready and
// are meant to happen only while the block is idle.
// ----------------------------------------------------------------------------
module pheromone_edge_table_selector
    import pet_pkg::*;
#(
    parameter int MAX_EDGES  = DEF_MAX_EDGES,
    parameter int MAX_DEGREE = DEF_MAX_DEGREE
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           mode,
    input  logic [INDEX_W-1:0]   edge_index,
    input  logic [VERTEX_W-1:0]  endpoint_a,
    input  logic [VERTEX_W-1:0]  endpoint_b,
    input  logic [LEVEL_W-1:0]   amount,
    input  logic [VERTEX_W-1:0]  current_vertex,
    input  logic [THR_W-1:0]     threshold,
    input  logic                 uniform_pick,
    output logic                 empty,
    input  logic                 pop,
    output logic [1:0]           status,
    output logic [VERTEX_W-1:0]  next_vertex,
    output logic [INDEX_W-1:0]   chosen_edge,
    output logic                 degree_overflow,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [EVAP_W-1:0]    cfg_data
);

    localparam int CW = $clog2(MAX_EDGES + 1);

    logic              cmd_valid;
    cmd_t              cmd;
    logic              cmd_pop;
    logic [CW-1:0]     edges_used;
    logic [EVAP_W-1:0] evap_amt;
    logic              res_valid;
    res_t              res;

    pet_front #(.MAX_EDGES(MAX_EDGES)) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .mode           (mode),
        .edge_index     (edge_index),
        .endpoint_a     (endpoint_a),
        .endpoint_b     (endpoint_b),
        .amount         (amount),
        .current_vertex (current_vertex),
        .threshold      (threshold),
        .uniform_pick   (uniform_pick),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_pop        (cmd_pop),
        .edges_used     (edges_used),
        .evap_amt       (evap_amt)
    );

    pet_back #(.MAX_EDGES(MAX_EDGES), .MAX_DEGREE(MAX_DEGREE)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop),
        .edges_used (edges_used),
        .evap_amt   (evap_amt),
        .res_valid  (res_valid),
        .res        (res),
        .res_pop    (pop)
    );

    // result slot presented as a queue head
    assign empty           = !res_valid;
    assign status          = res.status;
    assign next_vertex     = res.next_vertex;
    assign chosen_edge     = res.chosen_edge;
    assign degree_overflow = res.overflow;

endmodule

@@ bench/pheromone_edge_table_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pheromone_edge_table_checker
// Watches the item, result and config channels, keeps its own copy of the
// edge table, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module pheromone_edge_table_checker
    import pet_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic                 full,
    input  logic [1:0]           mode,
    input  logic [INDEX_W-1:0]   edge_index,
    input  logic [VERTEX_W-1:0]  endpoint_a,
    input  logic [VERTEX_W-1:0]  endpoint_b,
    input  logic [LEVEL_W-1:0]   amount,
    input  logic [VERTEX_W-1:0]  current_vertex,
    input  logic [THR_W-1:0]     threshold,
    input  logic                 uniform_pick,
    input  logic                 empty,
    input  logic                 pop,
    input  logic [1:0]           status,
    input  logic [VERTEX_W-1:0]  next_vertex,
    input  logic [INDEX_W-1:0]   chosen_edge,
    input  logic                 degree_overflow,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [EVAP_W-1:0]    cfg_data,
    output int                   fails,
    output int                   pending
);

    localparam int NE = DEF_MAX_EDGES;
    localparam int ND = DEF_MAX_DEGREE;

    typedef struct {
        status_t             st;
        logic [VERTEX_W-1:0] nv;
        logic [INDEX_W-1:0]  ce;
        logic                ov;
    } hop_t;

    logic [VERTEX_W-1:0] left_v  [NE];
    logic [VERTEX_W-1:0] right_v [NE];
    logic [LEVEL_W-1:0]  level   [NE];
    logic [ECNT_W-1:0]   edge_cnt;
    logic [EVAP_W-1:0]   evap_amt;
    hop_t                hop_q[$];

    function automatic int live_edges();
        return (edge_cnt > NE) ? NE : int'(edge_cnt);
    endfunction

    function automatic hop_t next_hop(logic [VERTEX_W-1:0] cur,
                                      logic [THR_W-1:0] thr, logic uni);
        hop_t h;
        int nb[ND];
        int ed[ND];
        int cnt;
        int pick;
        int t;
        bit over;
        longint unsigned sum;
        longint unsigned cum;
        cnt = 0;
        over = 0;
        sum = 0;
        cum = 0;
        h = '{ST_NONE, '0, '0, 1'b0};
        for (int i = 0; i < live_edges(); i++)
        begin
            // a self loop lands here twice, once per end
            if (right_v[i] == cur)
            begin
                if (cnt < ND)
                begin
                    nb[cnt] = left_v[i];
                    ed[cnt] = i;
                    cnt++;
                end
                else
                    over = 1;
            end
            if (left_v[i] == cur)
            begin
                if (cnt < ND)
                begin
                    nb[cnt] = right_v[i];
                    ed[cnt] = i;
                    cnt++;
                end
                else
                    over = 1;
            end
        end
        if (cnt == 0)
            return h;
        for (int i = 0; i < cnt; i++)
            sum += level[ed[i]];
        if (uni || sum == 0)
        begin
            pick = int'((longint'(thr) * cnt) >> 16);
            if (pick >= cnt)
                pick = cnt - 1;
        end
        else
        begin
            // stable descending sort
            for (int j = 0; j + 1 < cnt; j++)
                for (int i = 0; i + 1 < cnt - j; i++)
                    if (level[ed[i]] < level[ed[i+1]])
                    begin
                        t = ed[i]; ed[i] = ed[i+1]; ed[i+1] = t;
                        t = nb[i]; nb[i] = nb[i+1]; nb[i+1] = t;
                    end
            pick = cnt - 1;
            for (int i = 0; i < cnt; i++)
            begin
                cum += level[ed[i]];
                if (longint'(thr) * sum <= (cum << 16))
                begin
                    pick = i;
                    break;
                end
            end
        end
        h.st = ST_HOP;
        h.nv = VERTEX_W'(nb[pick]);
        h.ce = INDEX_W'(ed[pick]);
        h.ov = over;
        return h;
    endfunction

    function automatic void apply_update();
        int s;
        case (op_t'(mode))
            OP_LOAD:
            begin
                left_v[edge_index]  = endpoint_a;
                right_v[edge_index] = endpoint_b;
                level[edge_index]   = amount;
            end
            OP_DEPOSIT:
            begin
                s = int'(level[edge_index]) + int'(amount);
                level[edge_index] = (s > int'(LEVEL_MAX)) ? LEVEL_MAX : LEVEL_W'(s);
            end
            default:
                for (int i = 0; i < live_edges(); i++)
                    if (int'(level[i]) < int'(evap_amt) + int'(LEVEL_ONE))
                        level[i] = LEVEL_ONE;
                    else
                        level[i] = level[i] - evap_amt;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hop_t e;
        int   err;
        if (!rst_n)
        begin
            edge_cnt = '0;
            evap_amt = EVAP_W'(2048);
            fails    <= 0;
            hop_q.delete();
            pending  <= 0;
        end
        else
        begin
            err = 0;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_EDGE_COUNT)
                    edge_cnt = ECNT_W'(cfg_data);
                else if (cfg_index == CFG_EVAP_AMT)
                    evap_amt = cfg_data;
            end
            if (pop && !empty)
            begin
                if (hop_q.size() == 0)
                begin
                    $error("result with no item waiting");
                    err++;
                end
                else
                begin
                    e = hop_q.pop_front();
                    if (status !== e.st)
                    begin
                        $error("status: expected %0d actual %0d", e.st, status);
                        err++;
                    end
                    if (next_vertex !== e.nv)
                    begin
                        $error("next_vertex: expected %0d actual %0d", e.nv, next_vertex);
                        err++;
                    end
                    if (chosen_edge !== e.ce)
                    begin
                        $error("chosen_edge: expected %0d actual %0d", e.ce, chosen_edge);
                        err++;
                    end
                    if (degree_overflow !== e.ov)
                    begin
                        $error("degree_overflow: expected %0d actual %0d",
                               e.ov, degree_overflow);
                        err++;
                    end
                end
            end
            if (push && !full)
            begin
                if (op_t'(mode) == OP_SELECT)
                    hop_q.insert(hop_q.size(),
                                 next_hop(current_vertex, threshold, uniform_pick));
                else
                begin
                    apply_update();
                    hop_q.insert(hop_q.size(), '{ST_DONE, '0, '0, 1'b0});
                end
            end
            fails   <= fails + err;
            pending <= hop_q.size();
        end
    end

endmodule

@@ bench/pheromone_edge_table_selector_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pheromone_edge_table_selector_test
// Drives directed and random edge table items through the selector, with
// bursty input, a stalling receiver and config changes between phases; the
// checker beside the block does the predicting and comparing.
// ----------------------------------------------------------------------------
module pheromone_edge_table_selector_test;
    import pet_pkg::*;

    localparam int NE        = DEF_MAX_EDGES;
    localparam int IDLE_MAX  = 20000;   // cycles with no handshake at all
    localparam int HOLD_LEN  = 3000;    // long receiver hold-off

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    logic [1:0]           mode;
    logic [INDEX_W-1:0]   edge_index;
    logic [VERTEX_W-1:0]  endpoint_a;
    logic [VERTEX_W-1:0]  endpoint_b;
    logic [LEVEL_W-1:0]   amount;
    logic [VERTEX_W-1:0]  current_vertex;
    logic [THR_W-1:0]     threshold;
    logic                 uniform_pick;
    logic                 empty;
    logic                 pop;
    logic [1:0]           status;
    logic [VERTEX_W-1:0]  next_vertex;
    logic [INDEX_W-1:0]   chosen_edge;
    logic                 degree_overflow;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [EVAP_W-1:0]    cfg_data;
    int                   fails;
    int                   pending;

    // stimulus-side bookkeeping
    bit                   loaded [NE];   // edge written at least once
    int                   loaded_list[$];
    int                   table_len;     // edge count as the block sees it
    int                   vert_span;     // vertex ids drawn mostly from 0..span-1
    int                   items_sent;
    int                   burst_left;
    bit                   hold_req;
    int                   idle_cycles;

    pheromone_edge_table_selector dut (.*);

    pheromone_edge_table_checker chk (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // watchdog: any handshake restarts the count
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        @(posedge clk);
        while (idle_cycles < IDLE_MAX)
            @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

    // receiver: stall pattern changes at random; one long hold-off on request
    initial
    begin
        int hold_left;
        int style;
        bit held;
        hold_left = 0;
        style = 0;
        held = 0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held = 1;
                hold_left = HOLD_LEN;
            end
            if ($urandom_range(0, 63) == 0)
                style = $urandom_range(0, 3);
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                case (style)
                    0: pop <= 1'b1;
                    1: pop <= ($urandom_range(0, 1) == 0);
                    2: pop <= ($urandom_range(0, 9) == 0);
                    default: pop <= ($urandom_range(0, 3) != 0);
                endcase
        end
    end

    // one item; returns at the edge where it was taken with push still high, or after a random gap with push low
    task automatic send(op_t op, int idx, int a, int b, int amt,
                        int cur, int thr, bit uni);
        push           <= 1'b1;
        mode           <= op;
        edge_index     <= INDEX_W'(idx);
        endpoint_a     <= VERTEX_W'(a);
        endpoint_b     <= VERTEX_W'(b);
        amount         <= LEVEL_W'(amt);
        current_vertex <= VERTEX_W'(cur);
        threshold      <= THR_W'(thr);
        uniform_pick   <= uni;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
        if (op == OP_LOAD && !loaded[idx])
        begin
            loaded[idx] = 1;
            loaded_list.insert(loaded_list.size(), idx);
        end
        // burst over: usually drop push for a random gap
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 30);
            if ($urandom_range(0, 3) != 0)
            begin
                push <= 1'b0;
                repeat ($urandom_range(1, 12))
                    @(posedge clk);
            end
        end
    endtask

    // block idle: no item in flight, every result taken
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= EVAP_W'(data);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_EDGE_COUNT)
            table_len = (data > NE) ? NE : data;
    endtask

    function automatic int rand_level();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 24'hFFFFFF;
            2: return $urandom_range(0, 8191);
            3: return $urandom_range(24'hFF0000, 24'hFFFFFF);
            default: return $urandom & 24'hFFFFFF;
        endcase
    endfunction

    function automatic int rand_vertex();
        if (vert_span >= 128 || $urandom_range(0, 19) == 0)
            return $urandom_range(0, 127);
        return $urandom_range(0, vert_span - 1);
    endfunction

    function automatic int rand_thr();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 16'hFFFF;
            default: return $urandom & 16'hFFFF;
        endcase
    endfunction

    // every edge below the edge count must hold data before any scan
    task automatic fill_table();
        for (int i = 0; i < table_len; i++)
            if (!loaded[i])
                send(OP_LOAD, i, rand_vertex(), rand_vertex(), rand_level(), 0, 0, 0);
    endtask

    task automatic random_item();
        int r;
        int idx;
        r = $urandom_range(0, 99);
        if (r < 15)
        begin
            // loads land mostly inside the table, sometimes anywhere
            idx = ($urandom_range(0, 3) == 0 || table_len == 0) ?
                  $urandom_range(0, NE - 1) : $urandom_range(0, table_len - 1);
            send(OP_LOAD, idx, rand_vertex(), rand_vertex(), rand_level(),
                 $urandom & 7'h7F, $urandom & 16'hFFFF, $urandom_range(0, 1));
        end
        else if (r < 30 && loaded_list.size() > 0)
        begin
            idx = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
            send(OP_DEPOSIT, idx, $urandom & 7'h7F, $urandom & 7'h7F, rand_level(),
                 $urandom & 7'h7F, $urandom & 16'hFFFF, $urandom_range(0, 1));
        end
        else if (r < 40)
            send(OP_EVAP, $urandom & 9'h1FF, $urandom & 7'h7F, $urandom & 7'h7F,
                 $urandom & 24'hFFFFFF, $urandom & 7'h7F, $urandom & 16'hFFFF,
                 $urandom_range(0, 1));
        else
            send(OP_SELECT, $urandom & 9'h1FF, $urandom & 7'h7F, $urandom & 7'h7F,
                 $urandom & 24'hFFFFFF, rand_vertex(), rand_thr(),
                 ($urandom_range(0, 4) == 0));
    endtask

    initial
    begin
        int n;
        push           <= 1'b0;
        mode           <= OP_LOAD;
        edge_index     <= '0;
        endpoint_a     <= '0;
        endpoint_b     <= '0;
        amount         <= '0;
        current_vertex <= '0;
        threshold      <= '0;
        uniform_pick   <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_index      <= CFG_EDGE_COUNT;
        cfg_data       <= '0;
        hold_req       = 0;
        table_len      = 0;
        vert_span      = 8;
        items_sent     = 0;
        burst_left     = 0;
        rst_n          <= 1'b0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed ----
        // empty table: no neighbor, evaporate over nothing
        send(OP_SELECT, 0, 0, 0, 0, 1, 0, 0);
        send(OP_EVAP, 0, 0, 0, 0, 0, 0, 0);
        // small star around vertex 1, with a self loop and the level extremes
        send(OP_LOAD, 0, 1, 2, 24'hFFFFFF, 0, 0, 0);
        send(OP_LOAD, 1, 3, 1, 0, 0, 0, 0);
        send(OP_LOAD, 2, 1, 1, 4096, 0, 0, 0);
        send(OP_LOAD, 3, 127, 0, 0, 0, 0, 0);
        send(OP_LOAD, 4, 1, 5, 100, 0, 0, 0);
        send(OP_LOAD, 5, 6, 1, 100, 0, 0, 0);
        send(OP_LOAD, 511, 127, 127, 24'hFFFFFF, 0, 0, 0);
        drain();
        write_reg(CFG_EDGE_COUNT, 6);
        write_reg(CFG_EVAP_AMT, 65535);
        send(OP_SELECT, 0, 0, 0, 0, 1, 0, 0);
        send(OP_SELECT, 0, 0, 0, 0, 1, 16'hFFFF, 0);
        send(OP_SELECT, 0, 0, 0, 0, 1, 16'hFFFF, 1);
        // zero sum on vertex 0 falls back to the uniform pick
        send(OP_SELECT, 0, 0, 0, 0, 0, 16'h8000, 0);
        send(OP_SELECT, 0, 0, 0, 0, 127, 16'hFFFF, 0);
        // saturating deposit, then evaporate with every level but edge 0's hitting the floor
        send(OP_DEPOSIT, 0, 0, 0, 24'hFFFFFF, 0, 0, 0);
        send(OP_DEPOSIT, 1, 0, 0, 50, 0, 0, 0);
        send(OP_EVAP, 0, 0, 0, 0, 0, 0, 0);
        send(OP_SELECT, 0, 0, 0, 0, 1, 16'h4000, 0);
        // more edges at vertex 1 than MAX_DEGREE can gather
        for (int i = 6; i < 12; i++)
            send(OP_LOAD, i, 1, 10 + i, 1000 * i, 0, 0, 0);
        drain();
        write_reg(CFG_EDGE_COUNT, 12);
        write_reg(CFG_EVAP_AMT, 0);
        send(OP_SELECT, 0, 0, 0, 0, 1, 16'h7000, 0);
        send(OP_EVAP, 0, 0, 0, 0, 0, 0, 0);
        send(OP_SELECT, 0, 0, 0, 0, 1, 16'hFFFF, 1);

        // ---- random phases ----
        while (items_sent < 620)
        begin
            drain();
            n = $urandom_range(0, 9);
            write_reg(CFG_EDGE_COUNT, (n == 0) ? 0 :
                      (n < 8) ? $urandom_range(1, 24) : $urandom_range(25, 64));
            n = $urandom_range(0, 9);
            write_reg(CFG_EVAP_AMT, (n == 0) ? 0 : (n == 1) ? 65535 :
                      (n == 2) ? $urandom_range(0, 4096) : ($urandom & 16'hFFFF));
            vert_span = ($urandom_range(0, 4) == 0) ? 128 : $urandom_range(2, 12);
            fill_table();
            n = $urandom_range(40, 80);
            for (int k = 0; k < n; k++)
            begin
                // the long stall once, with the sender pressing on
                if (items_sent > 80)
                    hold_req = 1;
                random_item();
            end
        end

        // full table, then an edge count beyond the table that clamps to it
        drain();
        write_reg(CFG_EDGE_COUNT, NE);
        write_reg(CFG_EVAP_AMT, $urandom & 16'hFFFF);
        vert_span = 16;
        fill_table();
        for (int k = 0; k < 12; k++)
            random_item();
        drain();
        write_reg(CFG_EDGE_COUNT, 1023);
        for (int k = 0; k < 8; k++)
            random_item();

        drain();
        repeat (600)
            @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/pet_pkg.sv
rtl/pet_front.sv
rtl/pet_back.sv
rtl/pheromone_edge_table_selector.sv
bench/pheromone_edge_table_checker.sv
bench/pheromone_edge_table_selector_test.sv
